>>> sv/mvc_pkg.sv
// ----------------------------------------------------------------------------
// mvc_pkg
// Shared types and codes for the mesh vertex compaction remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package mvc_pkg;

  // width of the shared add/compare unit
  localparam int ALU_W = 24;

  // proxy index space: 16-bit indices, a 17-bit counter that can hold the limit
  localparam int PROXY_AW    = 16;
  localparam int PROXY_DEPTH = 65536;

  // item kinds
  localparam logic [1:0] MODE_REF_LOAD = 2'd0;
  localparam logic [1:0] MODE_HEADER   = 2'd1;
  localparam logic [1:0] MODE_TRIANGLE = 2'd2;
  localparam logic [1:0] MODE_FINISH   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_KEPT         = 3'd0;
  localparam logic [2:0] ST_UNRESOLVED   = 3'd1;
  localparam logic [2:0] ST_DEGENERATE   = 3'd2;
  localparam logic [2:0] ST_CLUSTER_DROP = 3'd3;
  localparam logic [2:0] ST_CLUSTER_OK   = 3'd4;
  localparam logic [2:0] ST_REF_LOADED   = 3'd5;
  localparam logic [2:0] ST_ACCEPTED     = 3'd6;
  localparam logic [2:0] ST_REJECTED     = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_SRC_COUNT = 2'd0;
  localparam logic [1:0] CFG_REF_SIZE  = 2'd1;
  localparam logic [1:0] CFG_TRI_TOTAL = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] ref_addr;
    logic [15:0] ref_value;
    logic [13:0] vertex_offset;
    logic [14:0] vertex_count;
    logic [21:0] triangle_offset;
    logic [19:0] triangle_count;
    logic [15:0] local_a;
    logic [15:0] local_b;
    logic [15:0] local_c;
  } mvc_in_t;

  typedef struct packed {
    logic [15:0] proxy_a;
    logic [15:0] proxy_b;
    logic [15:0] proxy_c;
    logic [2:0]  new_mask;
    logic [2:0]  status;
    logic [15:0] dropped_clusters;
    logic [19:0] dropped_triangles;
    logic [16:0] vertex_total;
  } mvc_out_t;

  // configuration as the engine sees it, limits already clamped
  typedef struct packed {
    logic [16:0] src_limit;
    logic [14:0] ref_size;
    logic [21:0] tri_total;
  } mvc_cfg_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } mvc_eng_sts_t;

endpackage

`default_nettype wire

>>> sv/mvc_alu.sv
// ----------------------------------------------------------------------------
// mvc_alu
// Shared add and compare unit: sum of two operands and sum greater than limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_alu import mvc_pkg::*; (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  input  logic [ALU_W-1:0] c_i,
  output logic [ALU_W-1:0] sum_o,
  output logic             gt_o
);

  // operands stay below 2^23, so the sum never wraps
  assign sum_o = a_i + b_i;
  assign gt_o  = (sum_o > c_i);

endmodule

`default_nettype wire

>>> sv/mvc_engine.sv
// ----------------------------------------------------------------------------
// mvc_engine
// Sequencer, tables and counters; every bound check and address sum goes through one shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_engine import mvc_pkg::*; #(
  parameter int MAX_SOURCE_VERTICES = 65536,
  parameter int MAX_REFS            = 16384
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  mvc_in_t      item_i,
  input  mvc_cfg_t     cfg_i,
  input  logic         res_ready_i,
  output mvc_eng_sts_t sts_o,
  output mvc_out_t     res_o
);

  localparam int REF_AW      = $clog2(MAX_REFS);
  localparam int REMAP_DEPTH = (MAX_SOURCE_VERTICES < PROXY_DEPTH) ?
                               MAX_SOURCE_VERTICES : PROXY_DEPTH;
  localparam int SRC_AW      = $clog2(REMAP_DEPTH);
  localparam logic [ALU_W-1:0] REF_LAST = ALU_W'(MAX_REFS - 1);
  localparam logic [ALU_W-1:0] ALU_ONE  = ALU_W'(1);
  localparam logic [1:0] LAST_CORNER = 2'd2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_REF   = 4'd1;
  localparam logic [3:0] S_H1    = 4'd2;
  localparam logic [3:0] S_H2    = 4'd3;
  localparam logic [3:0] S_H3    = 4'd4;
  localparam logic [3:0] S_CCNT  = 4'd5;
  localparam logic [3:0] S_CADR  = 4'd6;
  localparam logic [3:0] S_CSRC  = 4'd7;
  localparam logic [3:0] S_CIDX  = 4'd8;
  localparam logic [3:0] S_CCHK  = 4'd9;
  localparam logic [3:0] S_CALOC = 4'd10;
  localparam logic [3:0] S_TEND  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]  state_q;
  mvc_in_t     item_q;
  logic [1:0]  k_q;
  logic        fail_q;
  logic        fin_q;
  logic        drop_q;
  logic [21:0] t3_q;
  logic [15:0] src_q;
  logic [15:0] idx_q;
  logic [15:0] corner_q [3];
  logic [2:0]  mask_q;
  logic [2:0]  status_q;
  logic [13:0] cur_offset_q;
  logic [14:0] cur_count_q;
  logic        cur_ok_q;
  logic [16:0] next_proxy_q;
  logic [15:0] cl_drops_q;
  logic [19:0] tri_drops_q;

  logic [15:0] local_sel;
  logic [ALU_W-1:0] alu_a, alu_b, alu_c, alu_sum;
  logic        alu_gt;

  // ref table, remap table (source id -> proxy) and back table (proxy -> source id)
  logic [15:0]       ref_mem   [MAX_REFS];
  logic [15:0]       remap_mem [REMAP_DEPTH];
  logic [SRC_AW-1:0] back_mem  [PROXY_DEPTH];
  logic [15:0]       ref_rd_q;
  logic [15:0]       remap_rd_q;
  logic [SRC_AW-1:0] back_rd_q;

  logic [REF_AW-1:0]   ref_addr;
  logic                ref_we;
  logic [SRC_AW-1:0]   remap_addr;
  logic                remap_we;
  logic [PROXY_AW-1:0] back_addr;
  logic                back_we;

  always_comb begin
    case (k_q)
      2'd0:    local_sel = item_q.local_a;
      2'd1:    local_sel = item_q.local_b;
      default: local_sel = item_q.local_c;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    case (state_q)
      S_REF: begin
        alu_a = ALU_W'(item_q.ref_addr);
        alu_c = REF_LAST;
      end
      S_H1: begin
        alu_a = ALU_W'(item_q.vertex_offset);
        alu_b = ALU_W'(item_q.vertex_count);
        alu_c = ALU_W'(cfg_i.ref_size);
      end
      S_H2: begin
        alu_a = ALU_W'({item_q.triangle_count, 1'b0});
        alu_b = ALU_W'(item_q.triangle_count);
      end
      S_H3: begin
        alu_a = ALU_W'(item_q.triangle_offset);
        alu_b = ALU_W'(t3_q);
        alu_c = ALU_W'(cfg_i.tri_total);
      end
      S_CCNT: begin
        alu_a = ALU_W'(local_sel);
        alu_b = ALU_ONE;
        alu_c = ALU_W'(cur_count_q);
      end
      S_CADR: begin
        alu_a = ALU_W'(cur_offset_q);
        alu_b = ALU_W'(local_sel);
        alu_c = REF_LAST;
      end
      S_CSRC: begin
        alu_a = ALU_W'(ref_rd_q);
        alu_b = ALU_ONE;
        alu_c = ALU_W'(cfg_i.src_limit);
      end
      S_CIDX: begin
        alu_a = ALU_W'(remap_rd_q);
        alu_b = ALU_ONE;
        alu_c = ALU_W'(next_proxy_q);
      end
      default: ;
    endcase
  end

  mvc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .sum_o (alu_sum),
    .gt_o  (alu_gt)
  );

  assign ref_addr   = alu_sum[REF_AW-1:0];
  assign ref_we     = (state_q == S_REF) && !alu_gt;
  assign remap_addr = (state_q == S_CSRC) ? ref_rd_q[SRC_AW-1:0] : src_q[SRC_AW-1:0];
  assign remap_we   = (state_q == S_CALOC) && !next_proxy_q[16];
  assign back_addr  = (state_q == S_CIDX) ? remap_rd_q : next_proxy_q[PROXY_AW-1:0];
  assign back_we    = remap_we;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_addr] <= item_q.ref_value;
    end
    ref_rd_q <= ref_mem[ref_addr];
  end

  always_ff @(posedge clk_i) begin
    if (remap_we) begin
      remap_mem[remap_addr] <= next_proxy_q[PROXY_AW-1:0];
    end
    remap_rd_q <= remap_mem[remap_addr];
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_addr] <= src_q[SRC_AW-1:0];
    end
    back_rd_q <= back_mem[back_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      k_q          <= '0;
      fail_q       <= 1'b0;
      fin_q        <= 1'b0;
      drop_q       <= 1'b0;
      t3_q         <= '0;
      src_q        <= '0;
      idx_q        <= '0;
      corner_q[0]  <= '0;
      corner_q[1]  <= '0;
      corner_q[2]  <= '0;
      mask_q       <= '0;
      status_q     <= ST_KEPT;
      cur_offset_q <= '0;
      cur_count_q  <= '0;
      cur_ok_q     <= 1'b0;
      next_proxy_q <= '0;
      cl_drops_q   <= '0;
      tri_drops_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            item_q      <= item_i;
            k_q         <= '0;
            fail_q      <= 1'b0;
            fin_q       <= 1'b0;
            mask_q      <= '0;
            corner_q[0] <= '0;
            corner_q[1] <= '0;
            corner_q[2] <= '0;
            case (item_i.mode)
              MODE_REF_LOAD: state_q <= S_REF;
              MODE_HEADER:   state_q <= S_H1;
              MODE_TRIANGLE: begin
                if (cur_ok_q) begin
                  state_q <= S_CCNT;
                end else begin
                  status_q <= ST_CLUSTER_DROP;
                  state_q  <= S_DONE;
                end
              end
              default: begin
                status_q <= ((cl_drops_q != '0) || (tri_drops_q != '0)) ?
                            ST_REJECTED : ST_ACCEPTED;
                fin_q    <= 1'b1;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_REF: begin
          status_q <= ST_REF_LOADED;
          state_q  <= S_DONE;
        end
        S_H1: begin
          drop_q  <= alu_gt;
          state_q <= S_H2;
        end
        S_H2: begin
          t3_q    <= alu_sum[21:0];
          state_q <= S_H3;
        end
        S_H3: begin
          if (drop_q || alu_gt) begin
            if (cl_drops_q != '1) begin
              cl_drops_q <= cl_drops_q + 16'd1;
            end
            cur_ok_q <= 1'b0;
            status_q <= ST_CLUSTER_DROP;
          end else begin
            cur_offset_q <= item_q.vertex_offset;
            cur_count_q  <= item_q.vertex_count;
            cur_ok_q     <= 1'b1;
            status_q     <= ST_CLUSTER_OK;
          end
          state_q <= S_DONE;
        end
        // local index inside the cluster window
        S_CCNT: begin
          if (alu_gt) begin
            fail_q  <= 1'b1;
            state_q <= S_TEND;
          end else begin
            state_q <= S_CADR;
          end
        end
        // ref address in range, ref read issued this cycle
        S_CADR: begin
          if (alu_gt) begin
            fail_q  <= 1'b1;
            state_q <= S_TEND;
          end else begin
            state_q <= S_CSRC;
          end
        end
        // source id below the source count, remap read issued
        S_CSRC: begin
          src_q <= ref_rd_q;
          if (alu_gt) begin
            fail_q  <= 1'b1;
            state_q <= S_TEND;
          end else begin
            state_q <= S_CIDX;
          end
        end
        // stored proxy must lie below the allocation count to be live
        S_CIDX: begin
          idx_q <= remap_rd_q;
          if (!alu_gt) begin
            state_q <= S_CCHK;
          end else begin
            state_q <= S_CALOC;
          end
        end
        // live only if the back table points at this source id
        S_CCHK: begin
          if (back_rd_q == src_q[SRC_AW-1:0]) begin
            case (k_q)
              2'd0:    corner_q[0] <= idx_q;
              2'd1:    corner_q[1] <= idx_q;
              default: corner_q[2] <= idx_q;
            endcase
            if (k_q == LAST_CORNER) begin
              state_q <= S_TEND;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_CCNT;
            end
          end else begin
            state_q <= S_CALOC;
          end
        end
        S_CALOC: begin
          if (next_proxy_q[16]) begin
            fail_q  <= 1'b1;
            state_q <= S_TEND;
          end else begin
            case (k_q)
              2'd0:    corner_q[0] <= next_proxy_q[PROXY_AW-1:0];
              2'd1:    corner_q[1] <= next_proxy_q[PROXY_AW-1:0];
              default: corner_q[2] <= next_proxy_q[PROXY_AW-1:0];
            endcase
            mask_q[k_q]  <= 1'b1;
            next_proxy_q <= next_proxy_q + 17'd1;
            if (k_q == LAST_CORNER) begin
              state_q <= S_TEND;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_CCNT;
            end
          end
        end
        S_TEND: begin
          if (fail_q || (corner_q[0] == corner_q[1]) || (corner_q[1] == corner_q[2]) ||
              (corner_q[0] == corner_q[2])) begin
            if (tri_drops_q != '1) begin
              tri_drops_q <= tri_drops_q + 20'd1;
            end
            status_q    <= fail_q ? ST_UNRESOLVED : ST_DEGENERATE;
            corner_q[0] <= '0;
            corner_q[1] <= '0;
            corner_q[2] <= '0;
          end else begin
            status_q <= ST_KEPT;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            if (fin_q) begin
              next_proxy_q <= '0;
              cl_drops_q   <= '0;
              tri_drops_q  <= '0;
              cur_ok_q     <= 1'b0;
              cur_offset_q <= '0;
              cur_count_q  <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sts_o.busy      = (state_q != S_IDLE);
  assign sts_o.res_valid = (state_q == S_DONE);

  assign res_o.proxy_a           = corner_q[0];
  assign res_o.proxy_b           = corner_q[1];
  assign res_o.proxy_c           = corner_q[2];
  assign res_o.new_mask          = mask_q;
  assign res_o.status            = status_q;
  assign res_o.dropped_clusters  = cl_drops_q;
  assign res_o.dropped_triangles = tri_drops_q;
  assign res_o.vertex_total      = next_proxy_q;

endmodule

`default_nettype wire

>>> sv/mesh_vertex_compaction_remap.sv
// ----------------------------------------------------------------------------
// mesh_vertex_compaction_remap
// Cluster vertex index compaction: ref table, cluster checks, proxy remap.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall_o high until that
// item's result has moved into the output register; a finished result waits
// there, so the next item can be taken while it is still stalled. Every
// bound check and address sum goes through one shared add/compare unit, one
// step a cycle, and each table lookup is a registered read. A triangle
// resolves its corners in order: window, ref address, source and stored
// index checks, then the back table check or a new allocation; a corner that
// fails ends the triangle early.
// The remap table needs no clearing pass: an entry is live only when its stored
// proxy index lies below the allocation count and the back table at that
// index names the same source vertex, so a finish item clears it at once.
// Configuration writes are taken at any time, and must be made while no
// item is in flight.
`default_nettype none

module mesh_vertex_compaction_remap import mvc_pkg::*; #(
  parameter int MAX_SOURCE_VERTICES = 65536,
  parameter int MAX_REFS            = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  mvc_in_t     in_data_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output mvc_out_t    out_data_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [21:0] cfg_wdata_i
);

  // clamp limits, capped at what the register can hold
  localparam int SRC_CLAMP = (MAX_SOURCE_VERTICES > 131071) ? 131071 : MAX_SOURCE_VERTICES;
  localparam int REF_CLAMP = (MAX_REFS > 32767) ? 32767 : MAX_REFS;

  logic [16:0] src_cnt_q;
  logic [14:0] ref_size_q;
  logic [21:0] tri_total_q;

  mvc_cfg_t     cfg;
  mvc_eng_sts_t sts;
  mvc_out_t     res;
  mvc_out_t     out_data_q;
  logic         out_valid_q;
  logic         res_ready;
  logic         start;

  // configuration registers, index beyond the list is ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q   <= '0;
      ref_size_q  <= '0;
      tri_total_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_SRC_COUNT: src_cnt_q   <= cfg_wdata_i[16:0];
        CFG_REF_SIZE:  ref_size_q  <= cfg_wdata_i[14:0];
        CFG_TRI_TOTAL: tri_total_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // source count clamped to MAX_SOURCE_VERTICES and ref size to MAX_REFS, each within its register width
  assign cfg.src_limit = (int'(src_cnt_q) > SRC_CLAMP) ? 17'(SRC_CLAMP) : src_cnt_q;
  assign cfg.ref_size  = (int'(ref_size_q) > REF_CLAMP) ? 15'(REF_CLAMP) : ref_size_q;
  assign cfg.tri_total = tri_total_q;

  // engine takes a new item only when idle
  assign in_stall_o = sts.busy;
  assign start      = in_valid_i && !in_stall_o;

  mvc_engine #(
    .MAX_SOURCE_VERTICES (MAX_SOURCE_VERTICES),
    .MAX_REFS            (MAX_REFS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (in_data_i),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .sts_o       (sts),
    .res_o       (res)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sts.res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> sv/mvc_checker.sv
// ----------------------------------------------------------------------------
// mvc_checker
// Port-level checks on the compaction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mvc_checker import mvc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input mvc_out_t out_data_o
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  // in_stall_o is high in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted on back to back cycles");

  // allocation count never passes the proxy space
  a_vertex_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.vertex_total[16] || (out_data_o.vertex_total[15:0] == '0)))
    else $error("vertex total beyond proxy space");

  // only kept triangles carry proxy indices
  a_proxy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_KEPT) |->
      (out_data_o.proxy_a == '0) && (out_data_o.proxy_b == '0) && (out_data_o.proxy_c == '0))
    else $error("proxy index on a result that is not a kept triangle");

  // items that are not triangles never allocate
  a_mask_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_CLUSTER_OK) ||
                    (out_data_o.status == ST_REF_LOADED) ||
                    (out_data_o.status == ST_ACCEPTED) ||
                    (out_data_o.status == ST_REJECTED)) |-> (out_data_o.new_mask == '0))
    else $error("allocation reported on an item that is not a triangle");

endmodule

bind mesh_vertex_compaction_remap mvc_checker u_mvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> test/mesh_vertex_compaction_remap_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_vertex_compaction_remap_test
// Self-checking bench for the cluster vertex compaction and proxy remap block.
// A directed list covers window boundaries, partial allocation, degenerate and
// unresolved corners and finish handling. Random phases then send ref loads,
// kept cluster headers and triangle runs, mixed with raw items, under four
// register settings and three idling mixes. A scoreboard predicts each
// result and checks every field.
// ----------------------------------------------------------------------------
module mesh_vertex_compaction_remap_test;
  import mvc_pkg::*;

  localparam int SRC_CAP          = 65536;
  localparam int REF_CAP          = 16384;
  localparam int PROXY_CAP        = 65536;
  localparam int CLUSTER_DROP_MAX = 65535;
  localparam int TRI_DROP_MAX     = 1048575;
  localparam int HOLD_CYCLES      = 200;   // long receiver hold-off
  localparam int STUCK_LIMIT      = 3000;  // cycles with no handshake at all
  localparam int DRAIN_GAP        = 30;    // quiet cycles after the last result

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  mvc_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  mvc_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [21:0] cfg_wdata_i;

  // ---------------------------------------------------------------------------
  // predictor and result checker
  // ---------------------------------------------------------------------------
  class compaction_tracker;
    // remap table: source vertex -> proxy index
    bit          slot_used  [SRC_CAP];
    bit [15:0]   slot_proxy [SRC_CAP];
    // cluster vertex references, with a record of which entries were loaded
    bit [15:0]   ref_entry  [REF_CAP];
    bit          ref_loaded [REF_CAP];
    // current cluster window
    bit [13:0]   win_base;
    bit [14:0]   win_len;
    bit          win_ok;
    // counters
    bit [16:0]   alloc_count;
    bit [15:0]   cluster_drop_cnt;
    bit [19:0]   tri_drop_cnt;
    // registers
    bit [16:0]   src_count_reg;
    bit [14:0]   ref_size_reg;
    bit [21:0]   idx_total_reg;

    mvc_out_t    remap_results_q[$];
    int          failures;
    int          shown;
    int          results_seen;
    int          status_seen [8];
    int          peak_vertices;

    function void set_reg(logic [1:0] idx, logic [21:0] val);
      case (idx)
        CFG_SRC_COUNT: src_count_reg = val[16:0];
        CFG_REF_SIZE:  ref_size_reg  = val[14:0];
        CFG_TRI_TOTAL: idx_total_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned ref_limit();
      return (ref_size_reg > REF_CAP) ? REF_CAP : ref_size_reg;
    endfunction

    function int unsigned src_limit();
      return (src_count_reg > SRC_CAP) ? SRC_CAP : src_count_reg;
    endfunction

    function int pending();
      return remap_results_q.size();
    endfunction

    // a corner inside a kept window must point at a loaded ref entry,
    // otherwise it is pushed just past the window so it fails the bounds check
    function mvc_in_t guard_corners(mvc_in_t it);
      logic [15:0] locs [3];
      int k;
      locs = '{it.local_a, it.local_b, it.local_c};
      if (it.mode == MODE_TRIANGLE && win_ok) begin
        for (k = 0; k < 3; k++) begin
          if (locs[k] < win_len && !ref_loaded[win_base + locs[k]])
            locs[k] = 16'(win_len);
        end
      end
      it.local_a = locs[0];
      it.local_b = locs[1];
      it.local_c = locs[2];
      return it;
    endfunction

    // resolve one corner to a proxy index, allocating on first use
    function bit map_corner(logic [15:0] loc, output logic [15:0] proxy, output bit fresh);
      int unsigned addr;
      int unsigned src;
      fresh = 1'b0;
      proxy = '0;
      if (loc >= win_len)
        return 1'b0;
      addr = win_base + loc;
      if (addr >= REF_CAP)
        return 1'b0;
      src = ref_entry[addr];
      if (src >= src_limit())
        return 1'b0;
      if (!slot_used[src]) begin
        // proxy space exhausted
        if (alloc_count >= PROXY_CAP)
          return 1'b0;
        slot_used[src]  = 1'b1;
        slot_proxy[src] = alloc_count[15:0];
        alloc_count++;
        fresh = 1'b1;
      end
      proxy = slot_proxy[src];
      return 1'b1;
    endfunction

    function void count_tri_drop();
      if (tri_drop_cnt < TRI_DROP_MAX)
        tri_drop_cnt++;
    endfunction

    // work out the result of an accepted item and queue it
    function void accept_item(mvc_in_t it);
      mvc_out_t          res;
      logic [15:0]       corner [3];
      logic [15:0]       locs [3];
      bit                fresh;
      bit                ok;
      int                k;
      longint unsigned   win_end;
      longint unsigned   idx_end;
      res = '0;
      case (it.mode)
        MODE_REF_LOAD: begin
          ref_entry[it.ref_addr]  = it.ref_value;
          ref_loaded[it.ref_addr] = 1'b1;
          res.status = ST_REF_LOADED;
        end
        MODE_HEADER: begin
          win_end = it.vertex_offset;
          win_end += it.vertex_count;
          idx_end = it.triangle_count;
          idx_end = idx_end * 3 + it.triangle_offset;
          if (win_end > ref_limit() || idx_end > idx_total_reg) begin
            if (cluster_drop_cnt < CLUSTER_DROP_MAX)
              cluster_drop_cnt++;
            win_ok = 1'b0;
            res.status = ST_CLUSTER_DROP;
          end else begin
            win_base = it.vertex_offset;
            win_len  = it.vertex_count;
            win_ok   = 1'b1;
            res.status = ST_CLUSTER_OK;
          end
        end
        MODE_TRIANGLE: begin
          if (!win_ok) begin
            // no kept cluster: nothing allocated, nothing counted
            res.status = ST_CLUSTER_DROP;
          end else begin
            locs = '{it.local_a, it.local_b, it.local_c};
            corner = '{16'd0, 16'd0, 16'd0};
            ok = 1'b1;
            // corners allocated before a failing one keep their proxies
            for (k = 0; k < 3 && ok; k++) begin
              ok = map_corner(locs[k], corner[k], fresh);
              if (ok && fresh)
                res.new_mask[k] = 1'b1;
            end
            if (!ok) begin
              count_tri_drop();
              res.status = ST_UNRESOLVED;
            end else if (corner[0] == corner[1] || corner[1] == corner[2] ||
                         corner[0] == corner[2]) begin
              count_tri_drop();
              res.status = ST_DEGENERATE;
            end else begin
              res.proxy_a = corner[0];
              res.proxy_b = corner[1];
              res.proxy_c = corner[2];
              res.status  = ST_KEPT;
            end
          end
        end
        default: begin
          res.status = (cluster_drop_cnt != 0 || tri_drop_cnt != 0) ? ST_REJECTED : ST_ACCEPTED;
        end
      endcase
      res.dropped_clusters  = cluster_drop_cnt;
      res.dropped_triangles = tri_drop_cnt;
      res.vertex_total      = alloc_count;
      if (alloc_count > peak_vertices)
        peak_vertices = int'(alloc_count);
      // finish reports the counters, then clears them and the remap table
      if (it.mode == MODE_FINISH) begin
        foreach (slot_used[i])
          slot_used[i] = 1'b0;
        alloc_count      = '0;
        cluster_drop_cnt = '0;
        tri_drop_cnt     = '0;
        win_ok           = 1'b0;
        win_base         = '0;
        win_len          = '0;
      end
      remap_results_q = {remap_results_q, res};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("result %0d, %s: expected %0d, got %0d", results_seen, name, want, got);
        end
      end
    endfunction

    function void check_result(mvc_out_t got);
      mvc_out_t want;
      results_seen++;
      if (!$isunknown(got.status))
        status_seen[got.status]++;
      if (remap_results_q.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("result %0d arrived with nothing expected, status %0d",
                   results_seen, got.status);
        end
        return;
      end
      want = remap_results_q.pop_front();
      compare_field("proxy_a", want.proxy_a, got.proxy_a);
      compare_field("proxy_b", want.proxy_b, got.proxy_b);
      compare_field("proxy_c", want.proxy_c, got.proxy_c);
      compare_field("new_mask", want.new_mask, got.new_mask);
      compare_field("status", want.status, got.status);
      compare_field("dropped_clusters", want.dropped_clusters, got.dropped_clusters);
      compare_field("dropped_triangles", want.dropped_triangles, got.dropped_triangles);
      compare_field("vertex_total", want.vertex_total, got.vertex_total);
    endfunction

    function void report_coverage(int items);
      $display("%0d items, %0d results: %0d kept, %0d unresolved, %0d degenerate triangles",
               items, results_seen, status_seen[ST_KEPT], status_seen[ST_UNRESOLVED],
               status_seen[ST_DEGENERATE]);
      $display("%0d cluster drops, %0d kept, %0d ref loads, %0d/%0d finish ok/bad, peak %0d",
               status_seen[ST_CLUSTER_DROP], status_seen[ST_CLUSTER_OK],
               status_seen[ST_REF_LOADED], status_seen[ST_ACCEPTED],
               status_seen[ST_REJECTED], peak_vertices);
    endfunction
  endclass

  compaction_tracker tracker = new();

  int send_idle_pct;   // chance in percent that the sender skips a cycle
  int stall_pct;       // chance in percent that the receiver stalls
  int hold_asked;      // long hold-offs requested
  int items_sent;
  int quiet_cycles;

  mesh_vertex_compaction_remap #(
    .MAX_SOURCE_VERTICES (SRC_CAP),
    .MAX_REFS            (REF_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side: random stalls, plus a long hold-off on request,
  // counted here so the sender keeps pushing items meanwhile
  initial begin : receiver
    int hold_done;
    hold_done   = 0;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_asked != hold_done) begin
        hold_done++;
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
        @(posedge clk_i);
      end
    end
  end

  // every result is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(out_data_o);
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STUCK_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, tracker.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------
  function automatic mvc_in_t ref_item(int unsigned addr, int unsigned value);
    mvc_in_t it;
    it = '0;
    it.mode      = MODE_REF_LOAD;
    it.ref_addr  = addr[13:0];
    it.ref_value = value[15:0];
    return it;
  endfunction

  function automatic mvc_in_t header_item(int unsigned voff, int unsigned vcnt,
                                          int unsigned toff, int unsigned tcnt);
    mvc_in_t it;
    it = '0;
    it.mode            = MODE_HEADER;
    it.vertex_offset   = voff[13:0];
    it.vertex_count    = vcnt[14:0];
    it.triangle_offset = toff[21:0];
    it.triangle_count  = tcnt[19:0];
    return it;
  endfunction

  function automatic mvc_in_t tri_item(int unsigned a, int unsigned b, int unsigned c);
    mvc_in_t it;
    it = '0;
    it.mode    = MODE_TRIANGLE;
    it.local_a = a[15:0];
    it.local_b = b[15:0];
    it.local_c = c[15:0];
    return it;
  endfunction

  function automatic mvc_in_t finish_item();
    mvc_in_t it;
    it = '0;
    it.mode = MODE_FINISH;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // offer one item; acceptance is judged at the falling edge, where stall is stable
  task automatic send_item(mvc_in_t it);
    mvc_in_t safe;
    safe = tracker.guard_corners(it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= safe;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    tracker.accept_item(safe);
    items_sent++;
  endtask

  task automatic put_reg(logic [1:0] idx, logic [21:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic write_config(int unsigned src, int unsigned refs, int unsigned total);
    put_reg(CFG_SRC_COUNT, src[21:0]);
    put_reg(CFG_REF_SIZE, refs[21:0]);
    put_reg(CFG_TRI_TOTAL, total[21:0]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0)
      @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_idling(int mix);
    case (mix)
      0: begin send_idle_pct = 36; stall_pct = 70; end
      1: begin send_idle_pct = 70; stall_pct = 36; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // directed list, written for 1000 source vertices, 16 refs, 300 indices
  task automatic run_directed();
    send_item(tri_item(0, 1, 2));              // triangle before any header
    send_item(ref_item(0, 10));
    send_item(ref_item(1, 20));
    send_item(ref_item(2, 10));                // same source as entry 0
    send_item(ref_item(3, 999));               // last source in range
    send_item(ref_item(4, 1000));              // first source out of range
    send_item(ref_item(5, 65535));
    send_item(ref_item(6, 500));
    send_item(header_item(0, 16, 0, 100));     // both windows exactly full
    send_item(tri_item(0, 1, 3));              // three fresh proxies
    send_item(tri_item(3, 1, 0));              // all hits
    send_item(tri_item(0, 2, 1));              // two corners share a source
    send_item(tri_item(1, 1, 3));              // repeated local index
    send_item(tri_item(6, 4, 0));              // first corner allocates, second fails
    send_item(tri_item(0, 5, 1));              // source far out of range
    send_item(tri_item(0, 16, 1));             // local index one past the window
    send_item(tri_item(65535, 0, 1));
    send_item(header_item(1, 16, 0, 0));       // ref window one too long
    send_item(tri_item(0, 1, 3));              // after a dropped header
    send_item(header_item(0, 0, 1, 100));      // index window one too long
    send_item(header_item(16383, 32767, 4194303, 1048575));
    send_item(finish_item());                  // drops seen: rejected
    send_item(finish_item());                  // clean: accepted
    send_item(tri_item(0, 1, 3));              // window cleared by finish
    send_item(header_item(16, 0, 300, 0));     // empty windows at the very end
  endtask

  function automatic int unsigned pick_source();
    int unsigned lim;
    int unsigned pool;
    lim = tracker.src_limit();
    if ($urandom_range(9) < 2)
      return $urandom_range(65535);
    // small pool so sources repeat and the remap table gets hits
    pool = ((lim < 512) ? lim : 512) + 8;
    return $urandom_range(pool);
  endfunction

  function automatic int unsigned pick_local(int unsigned len);
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0)
      return $urandom_range(65535);
    if (r == 1 || len == 0)
      return len;
    return $urandom_range(len - 1);
  endfunction

  // well-formed run: load the window, a kept header, then triangles in it
  task automatic cluster_burst();
    int unsigned cap;
    int unsigned len;
    int unsigned room;
    int unsigned base;
    int unsigned total;
    int unsigned tmax;
    int unsigned tcnt;
    int unsigned toff;
    int unsigned tris;
    int unsigned k;
    cap = tracker.ref_limit();
    len = (cap == 0) ? 0 : $urandom_range(1, (cap < 24) ? cap : 24);
    room = cap - len;
    if ($urandom_range(3) == 0)
      base = $urandom_range(room);
    else
      base = $urandom_range((room < 255) ? room : 255);
    for (k = 0; k < len; k++) begin
      if (!tracker.ref_loaded[base + k] || $urandom_range(7) == 0)
        send_item(ref_item(base + k, pick_source()));
    end
    total = tracker.idx_total_reg;
    tmax  = total / 3;
    if (tmax > TRI_DROP_MAX)
      tmax = TRI_DROP_MAX;
    if ($urandom_range(1) == 0)
      tcnt = $urandom_range((tmax < 64) ? tmax : 64);
    else
      tcnt = $urandom_range(tmax);
    toff = $urandom_range(total - 3 * tcnt);
    send_item(header_item(base, len, toff, tcnt));
    tris = $urandom_range(2, 14);
    for (k = 0; k < tris; k++)
      send_item(tri_item(pick_local(len), pick_local(len), pick_local(len)));
    if ($urandom_range(7) == 0)
      send_item(finish_item());
  endtask

  // raw item with every field random
  task automatic noise_item();
    mvc_in_t     it;
    int unsigned r;
    r = $urandom_range(9);
    it.mode            = (r < 3) ? MODE_REF_LOAD : (r < 6) ? MODE_HEADER :
                         (r < 9) ? MODE_TRIANGLE : MODE_FINISH;
    it.ref_addr        = 14'($urandom_range(16383));
    it.ref_value       = 16'($urandom_range(65535));
    it.vertex_offset   = 14'($urandom_range(16383));
    it.vertex_count    = 15'($urandom_range(32767));
    it.triangle_offset = 22'($urandom_range(4194303));
    it.triangle_count  = 20'($urandom_range(1048575));
    it.local_a         = 16'($urandom_range(65535));
    it.local_b         = 16'($urandom_range(65535));
    it.local_c         = 16'($urandom_range(65535));
    send_item(it);
  endtask

  task automatic run_random(int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 85)
        cluster_burst();
      else
        noise_item();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_SRC_COUNT;
    cfg_wdata_i   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asked    = 0;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed checks on small windows
    write_config(1000, 16, 300);
    set_idling(0);
    run_directed();
    drain();

    // registers past their clamps, index total at its top
    write_config(131071, 32767, 4194303);
    set_idling(0);
    hold_asked <= hold_asked + 1;
    run_random(540);
    drain();

    // few source vertices so many corners fall out of range
    write_config(300, 200, 50000);
    set_idling(1);
    hold_asked <= hold_asked + 1;
    run_random(540);
    drain();

    // limits exactly at the table sizes
    write_config(65536, 16384, $urandom_range(3000000, 4194303));
    set_idling(2);
    hold_asked <= hold_asked + 1;
    run_random(500);
    drain();

    // everything zero: only empty windows survive
    write_config(0, 0, 0);
    run_random(40);
    drain();

    tracker.report_coverage(items_sent);
    if (tracker.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
